// File: hdl/delta_list_timeout_queue_core_macros.svh
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_core_macros: assertion macros
// Clocked property checks with reset disable for the timeout queue core.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMEOUT_QUEUE_CORE_MACROS_SVH
`define DELTA_LIST_TIMEOUT_QUEUE_CORE_MACROS_SVH
// Check that a property holds at every clock edge outside reset.
`define DLTQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the following cycle.
`define DLTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the timeout queue
// Opcodes, status codes and the per-cell command struct.
// ----------------------------------------------------------------------------
package dltq_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned MaxResults = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_SERVICE = 2'd3;

  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;
  localparam logic [2:0] ST_IDLE = 3'd5;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,   // cell at index writes id and delta
    CMD_SHR,    // cells above index take left neighbor (insert)
    CMD_SHL,    // cells at index and above take right neighbor (remove)
    CMD_WDELTA  // cell at index writes delta only
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  idx;
    logic [15:0] id;
    logic [31:0] delta;
  } cell_cmd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return s[31:0];
  endfunction
endpackage

// File: hdl/delta_list_timeout_queue_core.sv
// Tick, schedule and cancel walk one entry at a time before they answer; a schedule ends with
// an insert and, when an entry follows, a successor delta update; a cancel may add that update too.
// Service: returns expired entries one per cycle while the output is taken, up to 16.
// Throughput: one operation at a time; input is ready the cycle after the last result is taken.
// Reset clears the sequencer, the output and the entry count; cell contents stay undefined.
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_core: delta-list timeout queue
// Row of entry cells driven by one walking sequencer.
// ----------------------------------------------------------------------------
module delta_list_timeout_queue_core #(
  parameter int unsigned Depth = dltq_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // opcode[1:0], timer_id[17:2], delay_ticks[48:18]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // status[2:0], expired_id[18:3], overdue[50:19]
  output logic        m_axis_tlast_o
);
  logic [15:0] ids [Depth+1];
  logic [31:0] dls [Depth+1];
  logic [15:0] rd_id;
  logic [31:0] rd_delta;
  logic [6:0]  rd_idx;
  logic [2:0]  status;
  logic [15:0] oid;
  logic [31:0] ovd;
  dltq_pkg::cell_cmd_t cmd;

  assign ids[Depth] = '0;
  assign dls[Depth] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    dltq_cell #(.Index(g)) u_cell (
      .clk_i, .cmd_i(cmd),
      .left_id_i(g == 0 ? 16'd0 : ids[(g == 0) ? 0 : g-1]),
      .left_delta_i(g == 0 ? 32'd0 : dls[(g == 0) ? 0 : g-1]),
      .right_id_i(ids[g+1]), .right_delta_i(dls[g+1]),
      .id_o(ids[g]), .delta_o(dls[g])
    );
  end

  assign rd_id = (rd_idx < 7'(Depth)) ? ids[rd_idx[$clog2(Depth+1)-1:0]] : '0;
  assign rd_delta = (rd_idx < 7'(Depth)) ? dls[rd_idx[$clog2(Depth+1)-1:0]] : '0;

  dltq_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .op_i(s_axis_tdata_i[1:0]), .id_i(s_axis_tdata_i[17:2]),
    .delay_i(s_axis_tdata_i[48:18]),
    .rd_id_i(rd_id), .rd_delta_i(rd_delta), .rd_idx_o(rd_idx), .cmd_o(cmd),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .status_o(status), .out_id_o(oid), .overdue_o(ovd), .last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, ovd, oid, status};
endmodule

// File: hdl/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell: one list entry
// Holds id and delta; loads, or takes a neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module dltq_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  dltq_pkg::cell_cmd_t cmd_i,
  input  logic [15:0]         left_id_i,
  input  logic [31:0]         left_delta_i,
  input  logic [15:0]         right_id_i,
  input  logic [31:0]         right_delta_i,
  output logic [15:0]         id_o,
  output logic [31:0]         delta_o
);
  logic [15:0] id_q, id_d;
  logic [31:0] delta_q, delta_d;
  logic        at, above;

  assign at = (cmd_i.idx == 7'(Index));
  assign above = (cmd_i.idx < 7'(Index));

  always_comb begin
    id_d = id_q;
    delta_d = delta_q;
    case (cmd_i.cmd)
      dltq_pkg::CMD_LOAD: begin
        if (at) begin
          id_d = cmd_i.id;
          delta_d = cmd_i.delta;
        end
      end
      dltq_pkg::CMD_SHR: begin
        if (above) begin
          id_d = left_id_i;
          delta_d = left_delta_i;
        end
      end
      dltq_pkg::CMD_SHL: begin
        if (at || above) begin
          id_d = right_id_i;
          delta_d = right_delta_i;
        end
      end
      dltq_pkg::CMD_WDELTA: begin
        if (at) delta_d = cmd_i.delta;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    delta_q <= delta_d;
  end

  assign id_o = id_q;
  assign delta_o = delta_q;
endmodule

// File: hdl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl: operation sequencer
// Walks the cell row one entry a cycle and issues cell commands and results.
// ----------------------------------------------------------------------------
`include "delta_list_timeout_queue_core_macros.svh"
module dltq_ctrl #(
  parameter int unsigned Depth = dltq_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [15:0]         id_i,
  input  logic [30:0]         delay_i,
  input  logic [15:0]         rd_id_i,
  input  logic [31:0]         rd_delta_i,
  output logic [6:0]          rd_idx_o,
  output dltq_pkg::cell_cmd_t cmd_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [15:0]         out_id_o,
  output logic [31:0]         overdue_o,
  output logic                last_o
);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned KW = $clog2(dltq_pkg::MaxResults + 1);
  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_SCHED, S_LOAD, S_FIX, S_CANCEL, S_CFIX, S_SERV, S_OUT
  } state_e;

  state_e        state_q;
  logic [15:0]   id_q;
  logic [31:0]   t_q;         // remaining delay of a schedule walk
  logic [CW-1:0] cnt_q;
  logic [6:0]    i_q;
  logic [KW-1:0] k_q;
  logic          ov_q;
  logic [2:0]    st_q;
  logic [15:0]   oid_q;
  logic [31:0]   ovd_q;
  logic          last_q;
  logic          fix_q;
  logic [31:0]   fixv_q;
  logic          hp_q;        // one popped entry held back until its last flag is known
  logic [15:0]   hid_q;
  logic [31:0]   hdelta_q;
  logic [2:0]    st_d;
  logic [15:0]   oid_d;
  logic [31:0]   ovd_d;
  logic          last_d;
  logic          emit;
  logic [31:0]   dec;
  logic          in_list, has_next, walk, id_hit, due, fire, pos_delta;

  assign in_ready_o = (state_q == S_IDLE);
  assign rd_idx_o = i_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign out_id_o = oid_q;
  assign overdue_o = ovd_q;
  assign last_o = last_q;

  assign dec = (rd_delta_i == 32'h8000_0000) ? rd_delta_i : rd_delta_i - 32'd1;
  assign in_list = (7'(cnt_q) > i_q);
  assign has_next = (7'(cnt_q) > i_q + 7'd1);
  assign pos_delta = !rd_delta_i[31] && (rd_delta_i != '0);
  assign walk = in_list && ($signed({rd_delta_i[31], rd_delta_i}) < $signed({1'b0, t_q}));
  assign id_hit = in_list && (rd_id_i == id_q);
  assign due = (cnt_q != '0) && (rd_delta_i[31] || (rd_delta_i == '0)) &&
               (k_q != KW'(dltq_pkg::MaxResults));
  assign fire = !ov_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.cmd = dltq_pkg::CMD_HOLD;
    cmd_o.idx = i_q;
    case (state_q)
      S_TICK: begin
        if (in_list) begin
          cmd_o.cmd = dltq_pkg::CMD_WDELTA;
          cmd_o.delta = dec;
        end
      end
      S_SCHED: begin
        if (!walk) cmd_o.cmd = dltq_pkg::CMD_SHR;
      end
      S_LOAD: begin
        cmd_o.cmd = dltq_pkg::CMD_LOAD;
        cmd_o.id = id_q;
        cmd_o.delta = t_q;
      end
      S_FIX: begin
        // successor delta is at least the new delta, so no saturation
        cmd_o.cmd = dltq_pkg::CMD_WDELTA;
        cmd_o.delta = rd_delta_i - t_q;
      end
      S_CANCEL: begin
        if (id_hit) cmd_o.cmd = dltq_pkg::CMD_SHL;
      end
      S_CFIX: begin
        cmd_o.cmd = dltq_pkg::CMD_WDELTA;
        cmd_o.delta = dltq_pkg::sat_add(rd_delta_i, fixv_q);
      end
      S_SERV: begin
        if (fire && due) begin
          cmd_o.cmd = dltq_pkg::CMD_SHL;
          cmd_o.idx = '0;
        end
      end
      default: ;
    endcase
  end

  // Load the output register with the next result item.
  always_comb begin
    emit = 1'b0;
    st_d = dltq_pkg::ST_IDLE;
    oid_d = '0;
    ovd_d = '0;
    last_d = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && op_i == dltq_pkg::OP_SCHED && cnt_q == CW'(Depth)) begin
          emit = 1'b1;
          st_d = dltq_pkg::ST_FULL;
        end
      end
      S_TICK: begin
        if (!(in_list && dec[31])) emit = 1'b1;
      end
      S_LOAD: begin
        if (!fix_q) begin
          emit = 1'b1;
          st_d = dltq_pkg::ST_SCHEDULED;
        end
      end
      S_FIX: begin
        emit = 1'b1;
        st_d = dltq_pkg::ST_SCHEDULED;
      end
      S_CANCEL: begin
        if (!in_list) begin
          emit = 1'b1;
          st_d = dltq_pkg::ST_NOT_FOUND;
        end else if (id_hit && !(has_next && pos_delta)) begin
          emit = 1'b1;
          st_d = dltq_pkg::ST_CANCELLED;
          oid_d = id_q;
        end
      end
      S_CFIX: begin
        emit = 1'b1;
        st_d = dltq_pkg::ST_CANCELLED;
        oid_d = id_q;
      end
      S_SERV: begin
        if (fire && (hp_q || !due)) begin
          emit = 1'b1;
          if (hp_q) begin
            st_d = dltq_pkg::ST_EXPIRED;
            oid_d = hid_q;
            ovd_d = hdelta_q;
            last_d = !due;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      id_q <= '0;
      t_q <= '0;
      cnt_q <= '0;
      i_q <= '0;
      k_q <= '0;
      ov_q <= 1'b0;
      st_q <= '0;
      oid_q <= '0;
      ovd_q <= '0;
      last_q <= 1'b0;
      fix_q <= 1'b0;
      fixv_q <= '0;
      hp_q <= 1'b0;
      hid_q <= '0;
      hdelta_q <= '0;
    end else begin
      if (emit) begin
        ov_q <= 1'b1;
        st_q <= st_d;
        oid_q <= oid_d;
        ovd_q <= ovd_d;
        last_q <= last_d;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            id_q <= id_i;
            t_q <= {1'b0, (delay_i == '0) ? 31'd1 : delay_i};
            i_q <= '0;
            k_q <= '0;
            fix_q <= 1'b0;
            hp_q <= 1'b0;
            case (op_i)
              dltq_pkg::OP_TICK: state_q <= S_TICK;
              dltq_pkg::OP_SCHED: begin
                if (cnt_q == CW'(Depth)) state_q <= S_OUT;
                else state_q <= S_SCHED;
              end
              dltq_pkg::OP_CANCEL: state_q <= S_CANCEL;
              dltq_pkg::OP_SERVICE: state_q <= S_SERV;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_TICK: begin
          if (in_list && dec[31]) i_q <= i_q + 7'd1;
          else state_q <= S_OUT;
        end
        S_SCHED: begin
          if (walk) begin
            if (pos_delta) t_q <= t_q - rd_delta_i;
            i_q <= i_q + 7'd1;
          end else begin
            fix_q <= in_list;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q <= cnt_q + CW'(1);
          if (fix_q) begin
            i_q <= i_q + 7'd1;
            state_q <= S_FIX;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_FIX: state_q <= S_OUT;
        S_CANCEL: begin
          if (!in_list) begin
            state_q <= S_OUT;
          end else if (id_hit) begin
            // successor moves into this slot; fold the removed delta into it next
            cnt_q <= cnt_q - CW'(1);
            fixv_q <= rd_delta_i;
            if (has_next && pos_delta) state_q <= S_CFIX;
            else state_q <= S_OUT;
          end else begin
            i_q <= i_q + 7'd1;
          end
        end
        S_CFIX: state_q <= S_OUT;
        S_SERV: begin
          if (fire) begin
            if (due) begin
              cnt_q <= cnt_q - CW'(1);
              k_q <= k_q + KW'(1);
              hp_q <= 1'b1;
              hid_q <= rd_id_i;
              hdelta_q <= rd_delta_i;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (ov_q && out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DLTQ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(Depth))
  `DLTQ_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> !ov_q)
  `DLTQ_ASSERT(a_k_bound, clk_i, rst_ni, k_q <= KW'(dltq_pkg::MaxResults))
  `DLTQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q && $stable(ovd_q))
endmodule
